/* hw/rtl/iase_pkg.sv */
// ----------------------------------------------------------------------------
// iase_pkg: shared types for the infix add/subtract evaluator
// Stack depth, entry types, cell commands and the control/view structs
// passed between the sequencer and the stack chain.
// ----------------------------------------------------------------------------
package iase_pkg;

  // depth of both the operand and the operator stack
  localparam int unsigned STACK_DEPTH = 64;
  // count width, able to hold the depth itself
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [31:0]      opnd_t;
  typedef logic [1:0]       oper_t;

  // operator stack entries
  localparam oper_t OP_LP    = 2'd0;
  localparam oper_t OP_PLUS  = 2'd1;
  localparam oper_t OP_MINUS = 2'd2;

  // what one stack cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_ABOVE,
    CELL_LOAD_BELOW
  } cell_cmd_e;

  // sequencer to chain: per-lane commands for the top cell and the rest
  typedef struct packed {
    cell_cmd_e opnd_top_cmd;
    cell_cmd_e opnd_rest_cmd;
    opnd_t     opnd_in;
    cell_cmd_e oper_top_cmd;
    cell_cmd_e oper_rest_cmd;
    oper_t     oper_in;
  } chain_ctl_t;

  // chain to sequencer: the entries nearest the top
  typedef struct packed {
    opnd_t opnd0;
    opnd_t opnd1;
    oper_t oper0;
  } chain_top_t;

endpackage

/* hw/rtl/iase_cell.sv */
// ----------------------------------------------------------------------------
// iase_cell: one stack cell
// Holds one operand entry and one operator entry; each lane holds, loads
// from the neighbor above (push) or from the neighbor below (pop).
// ----------------------------------------------------------------------------
module iase_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iase_pkg::cell_cmd_e opnd_cmd_i,
  input  iase_pkg::opnd_t     opnd_above_i,
  input  iase_pkg::opnd_t     opnd_below_i,
  output iase_pkg::opnd_t     opnd_o,
  input  iase_pkg::cell_cmd_e oper_cmd_i,
  input  iase_pkg::oper_t     oper_above_i,
  input  iase_pkg::oper_t     oper_below_i,
  output iase_pkg::oper_t     oper_o
);
  import iase_pkg::*;

  opnd_t opnd_q, opnd_d;
  oper_t oper_q, oper_d;

  // operand lane select
  always_comb begin
    unique case (opnd_cmd_i)
      CELL_LOAD_ABOVE: opnd_d = opnd_above_i;
      CELL_LOAD_BELOW: opnd_d = opnd_below_i;
      default:         opnd_d = opnd_q;
    endcase
  end

  // operator lane select
  always_comb begin
    unique case (oper_cmd_i)
      CELL_LOAD_ABOVE: oper_d = oper_above_i;
      CELL_LOAD_BELOW: oper_d = oper_below_i;
      default:         oper_d = oper_q;
    endcase
  end

  // entry registers, cleared so the top operand reads zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_q <= '0;
      oper_q <= OP_LP;
    end else begin
      opnd_q <= opnd_d;
      oper_q <= oper_d;
    end
  end

  assign opnd_o = opnd_q;
  assign oper_o = oper_q;

endmodule

/* hw/rtl/iase_chain.sv */
// ----------------------------------------------------------------------------
// iase_chain: row of stack cells
// Cell 0 is the top of both stacks; pushes shift entries away from the top,
// pops shift them toward it, one neighbor step per cycle.
// ----------------------------------------------------------------------------
module iase_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iase_pkg::chain_ctl_t ctl_i,
  output iase_pkg::chain_top_t top_o
);
  import iase_pkg::*;

  opnd_t opnd_val [STACK_DEPTH];
  oper_t oper_val [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    opnd_t     opnd_above, opnd_below;
    oper_t     oper_above, oper_below;
    cell_cmd_e opnd_cmd, oper_cmd;

    // neighbor wiring: the top takes fresh data, the bottom pops in zero
    if (i == 0) begin : g_top
      assign opnd_above = ctl_i.opnd_in;
      assign oper_above = ctl_i.oper_in;
      assign opnd_cmd   = ctl_i.opnd_top_cmd;
      assign oper_cmd   = ctl_i.oper_top_cmd;
    end else begin : g_inner
      assign opnd_above = opnd_val[i-1];
      assign oper_above = oper_val[i-1];
      assign opnd_cmd   = ctl_i.opnd_rest_cmd;
      assign oper_cmd   = ctl_i.oper_rest_cmd;
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign opnd_below = '0;
      assign oper_below = OP_LP;
    end else begin : g_mid
      assign opnd_below = opnd_val[i+1];
      assign oper_below = oper_val[i+1];
    end

    iase_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .opnd_cmd_i   (opnd_cmd),
      .opnd_above_i (opnd_above),
      .opnd_below_i (opnd_below),
      .opnd_o       (opnd_val[i]),
      .oper_cmd_i   (oper_cmd),
      .oper_above_i (oper_above),
      .oper_below_i (oper_below),
      .oper_o       (oper_val[i])
    );
  end

  // top view
  assign top_o.opnd0 = opnd_val[0];
  assign top_o.opnd1 = opnd_val[1];
  assign top_o.oper0 = oper_val[0];

endmodule

/* hw/rtl/iase_seq.sv */
// ----------------------------------------------------------------------------
// iase_seq: character decode and stack sequencer
// Decodes each character, accumulates numbers, applies the pending operator
// with one adder and drives the stack chain; flushes at the end of an
// expression and hands the top operand out.
// ----------------------------------------------------------------------------
module iase_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_char_i,
  input  logic                 in_last_i,
  input  logic                 out_free_i,
  output logic                 res_valid_o,
  output iase_pkg::opnd_t      res_value_o,
  output logic                 res_ovf_o,
  output iase_pkg::chain_ctl_t chain_ctl_o,
  input  iase_pkg::chain_top_t chain_top_i
);
  import iase_pkg::*;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // sequencer states
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_RPOP  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  typedef enum logic [2:0] {
    PC_NONE, PC_LP, PC_PLUS, PC_MINUS, PC_DIGIT, PC_RP, PC_OTHER
  } prev_class_e;

  localparam cnt_t CNT_FULL = cnt_t'(STACK_DEPTH);
  localparam cnt_t CNT_ONE  = cnt_t'(1);

  logic [1:0]  state_q, state_d;
  opnd_t       acc_q, acc_d;
  logic        innum_q, innum_d;
  prev_class_e prev_q, prev_d;
  logic        ovf_q, ovf_d;
  logic        last_q, last_d;
  cnt_t        opnd_cnt_q, opnd_cnt_d;
  cnt_t        oper_cnt_q, oper_cnt_d;

  logic  accept, top_is_op, sign_prev, need_rpop;
  logic  is_space, is_digit, is_lp, is_rp, is_plus, is_minus;
  logic  push_req, push_ok, apply_req, apply_ok, finish;
  logic  oper_push, oper_pop, oper_repl;
  oper_t oper_val;
  opnd_t push_val, acc_x10, alu_l, alu_r, alu_res;

  // character classes
  assign is_space = (in_char_i == CH_SPACE);
  assign is_digit = (in_char_i >= CH_ZERO) && (in_char_i <= CH_NINE);
  assign is_lp    = (in_char_i == CH_LP);
  assign is_rp    = (in_char_i == CH_RP);
  assign is_plus  = (in_char_i == CH_PLUS);
  assign is_minus = (in_char_i == CH_MINUS);

  assign in_ready_o = (state_q == ST_RUN);
  assign accept     = in_valid_i && in_ready_o;
  assign top_is_op  = (oper_cnt_q != '0) && (chain_top_i.oper0 != OP_LP);
  assign sign_prev  = (prev_q == PC_LP) || (prev_q == PC_PLUS) || (prev_q == PC_MINUS);

  // accumulator times ten plus the new digit
  assign acc_x10 = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, in_char_i[3:0]};

  // per-character decisions and the end-of-expression flush
  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    innum_d   = innum_q;
    prev_d    = prev_q;
    last_d    = last_q;
    push_req  = 1'b0;
    push_val  = acc_q;
    apply_req = 1'b0;
    oper_push = 1'b0;
    oper_pop  = 1'b0;
    oper_repl = 1'b0;
    oper_val  = OP_LP;
    finish    = 1'b0;
    need_rpop = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          last_d = in_last_i;
          if (is_digit) begin
            acc_d   = acc_x10;
            innum_d = 1'b1;
            prev_d  = PC_DIGIT;
          end else if (!is_space) begin
            // a finished number goes on the operand stack first
            if (innum_q) begin
              push_req = 1'b1;
              push_val = acc_q;
              acc_d    = '0;
              innum_d  = 1'b0;
            end
            if (is_lp) begin
              oper_push = 1'b1;
              oper_val  = OP_LP;
              prev_d    = PC_LP;
            end else if (is_rp) begin
              prev_d = PC_RP;
              if (top_is_op) begin
                apply_req = 1'b1;
                oper_pop  = 1'b1;
                need_rpop = 1'b1;
              end else if (oper_cnt_q != '0) begin
                oper_pop = 1'b1;
              end
            end else begin
              // unary sign: a zero operand stands in on the left
              if (!innum_q && sign_prev) begin
                push_req = 1'b1;
                push_val = '0;
              end
              apply_req = top_is_op;
              oper_val  = is_plus ? OP_PLUS : OP_MINUS;
              oper_repl = top_is_op;
              oper_push = !top_is_op;
              if (is_plus) begin
                prev_d = PC_PLUS;
              end else if (is_minus) begin
                prev_d = PC_MINUS;
              end else begin
                prev_d = PC_OTHER;
              end
            end
          end
          if (need_rpop) begin
            state_d = ST_RPOP;
          end else if (in_last_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_RPOP: begin
        // drop the matching open parenthesis
        if (oper_cnt_q != '0) begin
          oper_pop = 1'b1;
        end
        state_d = last_q ? ST_FLUSH : ST_RUN;
      end
      ST_FLUSH: begin
        if (innum_q) begin
          push_req = 1'b1;
          push_val = acc_q;
          acc_d    = '0;
          innum_d  = 1'b0;
        end else if (oper_cnt_q != '0) begin
          oper_pop  = 1'b1;
          apply_req = (chain_top_i.oper0 != OP_LP);
        end else if (out_free_i) begin
          finish  = 1'b1;
          acc_d   = '0;
          innum_d = 1'b0;
          prev_d  = PC_NONE;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // operand push / apply and operator stack moves
  assign push_ok  = push_req && (opnd_cnt_q != CNT_FULL);
  assign apply_ok = apply_req && (push_ok || (opnd_cnt_q >= cnt_t'(2)));
  assign alu_l    = push_ok ? chain_top_i.opnd0 : chain_top_i.opnd1;
  assign alu_r    = push_ok ? push_val : chain_top_i.opnd0;
  assign alu_res  = (chain_top_i.oper0 == OP_PLUS) ? (alu_l + alu_r) : (alu_l - alu_r);

  always_comb begin
    chain_ctl_o.opnd_top_cmd  = CELL_HOLD;
    chain_ctl_o.opnd_rest_cmd = CELL_HOLD;
    chain_ctl_o.opnd_in       = alu_res;
    chain_ctl_o.oper_top_cmd  = CELL_HOLD;
    chain_ctl_o.oper_rest_cmd = CELL_HOLD;
    chain_ctl_o.oper_in       = oper_val;
    opnd_cnt_d = opnd_cnt_q;
    oper_cnt_d = oper_cnt_q;
    ovf_d      = ovf_q;

    if (push_req && !push_ok) begin
      ovf_d = 1'b1;
    end

    // operand lane
    if (finish) begin
      chain_ctl_o.opnd_top_cmd = CELL_LOAD_ABOVE;
      chain_ctl_o.opnd_in      = '0;
      opnd_cnt_d               = CNT_ONE;
    end else if (push_ok && apply_ok) begin
      chain_ctl_o.opnd_top_cmd = CELL_LOAD_ABOVE;
    end else if (push_ok) begin
      chain_ctl_o.opnd_top_cmd  = CELL_LOAD_ABOVE;
      chain_ctl_o.opnd_rest_cmd = CELL_LOAD_ABOVE;
      chain_ctl_o.opnd_in       = push_val;
      opnd_cnt_d                = opnd_cnt_q + CNT_ONE;
    end else if (apply_ok) begin
      chain_ctl_o.opnd_top_cmd  = CELL_LOAD_ABOVE;
      chain_ctl_o.opnd_rest_cmd = CELL_LOAD_BELOW;
      opnd_cnt_d                = opnd_cnt_q - CNT_ONE;
    end

    // operator lane
    if (finish) begin
      oper_cnt_d = '0;
    end else if (oper_push) begin
      if (oper_cnt_q != CNT_FULL) begin
        chain_ctl_o.oper_top_cmd  = CELL_LOAD_ABOVE;
        chain_ctl_o.oper_rest_cmd = CELL_LOAD_ABOVE;
        oper_cnt_d                = oper_cnt_q + CNT_ONE;
      end else begin
        ovf_d = 1'b1;
      end
    end else if (oper_pop) begin
      chain_ctl_o.oper_top_cmd  = CELL_LOAD_BELOW;
      chain_ctl_o.oper_rest_cmd = CELL_LOAD_BELOW;
      oper_cnt_d                = oper_cnt_q - CNT_ONE;
    end else if (oper_repl) begin
      chain_ctl_o.oper_top_cmd = CELL_LOAD_ABOVE;
    end
  end

  // result toward the output register
  assign res_valid_o = finish;
  assign res_value_o = chain_top_i.opnd0;
  assign res_ovf_o   = ovf_q;

  // sequencer and expression state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      acc_q      <= '0;
      innum_q    <= 1'b0;
      prev_q     <= PC_NONE;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      opnd_cnt_q <= CNT_ONE;
      oper_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      innum_q    <= innum_d;
      prev_q     <= prev_d;
      ovf_q      <= ovf_d;
      last_q     <= last_d;
      opnd_cnt_q <= opnd_cnt_d;
      oper_cnt_q <= oper_cnt_d;
    end
  end

endmodule

/* hw/rtl/infix_add_sub_evaluator_top.sv */
// ----------------------------------------------------------------------------
// infix_add_sub_evaluator_top: streaming infix +/- expression evaluator
// Reads an expression one character per word and returns its value when
// the last character has been taken.
//
//   channel  | dir | words
//   ---------+-----+-----------------------------------------------------
//   s_axis   | in  | one character; tlast marks the end of the expression
//   m_axis   | out | one word per expression: value, overflow flag
//
// An ordinary character is taken straight away; a ')' that closes a level
// with a pending operator also passes ST_RPOP. After the last character the
// flush pushes a pending number, pops each operator-stack entry left open,
// then emits, since the cell chain moves the stacks one entry per cycle.
// Reset leaves the operator stack empty, one zero operand; no clearing pass.
// The result sits in an output register, so characters keep flowing while
// it waits; only the emit of the next result waits for that register.
// ----------------------------------------------------------------------------
module infix_add_sub_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic [0:0]  m_axis_tuser    // [0] overflowed
);
  import iase_pkg::*;

  chain_ctl_t chain_ctl;
  chain_top_t chain_top;
  logic       res_valid, res_ovf, out_free;
  opnd_t      res_value;
  logic       out_valid_q;
  opnd_t      out_value_q;
  logic       out_ovf_q;

  assign out_free = !out_valid_q || m_axis_tready;

  // decode and sequencing
  iase_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .res_ovf_o   (res_ovf),
    .chain_ctl_o (chain_ctl),
    .chain_top_i (chain_top)
  );

  // operand and operator stacks
  iase_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (chain_ctl),
    .top_o  (chain_top)
  );

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_value_q <= res_value;
      out_ovf_q   <= res_ovf;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_value_q;
  assign m_axis_tuser[0] = out_ovf_q;

endmodule

/* tb/tb_infix_add_sub_evaluator_top.sv */
// ----------------------------------------------------------------------------
// tb_infix_add_sub_evaluator_top: self-checking bench for the infix evaluator
// Streams expressions in one character per word. A scoreboard model with
// its own two stacks works out each value and overflow flag, and every
// output word is checked against it. The stimulus is a short directed set,
// random well-formed expressions mixed with noise, and deep nesting last.
// ----------------------------------------------------------------------------
module tb_infix_add_sub_evaluator_top;
  import iase_pkg::*;

  // character codes the expression syntax knows
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int RANDOM_CHARS = 560;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 20;
  localparam int MAX_PRINTS   = 40;

  // what the last non-space character was, for the unary sign rule
  typedef enum logic [2:0] {
    PREV_NONE,
    PREV_LPAREN,
    PREV_PLUS,
    PREV_MINUS,
    PREV_DIGIT,
    PREV_RPAREN,
    PREV_OTHER
  } prev_kind_e;

  typedef struct {
    logic [7:0] code;
    logic       is_end;
  } char_word_t;

  typedef struct {
    opnd_t value;
    logic  ovf;
  } eval_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;    // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] value
  logic [0:0]  m_axis_tuser;           // [0] overflowed

  infix_add_sub_evaluator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  char_word_t   char_q[$];
  eval_result_t value_q[$];

  int err_cnt = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int exprs_built = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit ovf_seen = 1'b0;

  // ---------------------------------------------------------------------
  // evaluator model state
  // ---------------------------------------------------------------------
  opnd_t      opnd_stk [STACK_DEPTH];
  cnt_t       opnd_cnt;
  oper_t      oper_stk [STACK_DEPTH];
  cnt_t       oper_cnt;
  opnd_t      num_acc;
  logic       in_num;
  prev_kind_e prev_kind;
  logic       ovf_sticky;

  function automatic void clear_expression();
    opnd_stk[0] = '0;
    opnd_cnt    = 1;
    oper_cnt    = 0;
    num_acc     = '0;
    in_num      = 1'b0;
    prev_kind   = PREV_NONE;
  endfunction

  function automatic void push_opnd(opnd_t v);
    if (opnd_cnt < STACK_DEPTH) begin
      opnd_stk[opnd_cnt] = v;
      opnd_cnt++;
    end else begin
      ovf_sticky = 1'b1;
    end
  endfunction

  function automatic void push_oper(oper_t op);
    if (oper_cnt < STACK_DEPTH) begin
      oper_stk[oper_cnt] = op;
      oper_cnt++;
    end else begin
      ovf_sticky = 1'b1;
    end
  endfunction

  // an operator without two operands is dropped
  function automatic void apply_oper(oper_t op);
    opnd_t lhs, rhs;
    if (opnd_cnt < 2) return;
    rhs = opnd_stk[opnd_cnt - 1];
    lhs = opnd_stk[opnd_cnt - 2];
    opnd_cnt--;
    opnd_stk[opnd_cnt - 1] = (op == OP_PLUS) ? lhs + rhs : lhs - rhs;
  endfunction

  // fold operators down to the nearest open paren
  function automatic void reduce_level();
    while (oper_cnt > 0 && oper_stk[oper_cnt - 1] != OP_LP) begin
      oper_cnt--;
      apply_oper(oper_stk[oper_cnt]);
    end
  endfunction

  // take one character; on the end marker queue the value it yields
  function automatic void evaluate_char(logic [7:0] c, logic is_end);
    eval_result_t res;
    oper_t        op;
    if (c != CH_SPACE) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        num_acc   = num_acc * 10 + (c - CH_ZERO);
        in_num    = 1'b1;
        prev_kind = PREV_DIGIT;
      end else begin
        if (in_num) begin
          push_opnd(num_acc);
          num_acc = '0;
          in_num  = 1'b0;
        end
        if (c == CH_LPAREN) begin
          push_oper(OP_LP);
          prev_kind = PREV_LPAREN;
        end else if (c == CH_RPAREN) begin
          reduce_level();
          if (oper_cnt > 0) oper_cnt--;
          prev_kind = PREV_RPAREN;
        end else begin
          // a sign right after an open paren or operator gets a zero operand
          if (prev_kind == PREV_LPAREN || prev_kind == PREV_PLUS ||
              prev_kind == PREV_MINUS)
            push_opnd('0);
          reduce_level();
          if (c == CH_PLUS) begin
            push_oper(OP_PLUS);
            prev_kind = PREV_PLUS;
          end else begin
            push_oper(OP_MINUS);
            prev_kind = (c == CH_MINUS) ? PREV_MINUS : PREV_OTHER;
          end
        end
      end
    end
    if (!is_end) return;
    if (in_num) begin
      push_opnd(num_acc);
      num_acc = '0;
      in_num  = 1'b0;
    end
    // unwind everything, open parens just vanish
    while (oper_cnt > 0) begin
      oper_cnt--;
      op = oper_stk[oper_cnt];
      if (op != OP_LP) apply_oper(op);
    end
    res.value = opnd_stk[opnd_cnt - 1];
    res.ovf   = ovf_sticky;
    value_q.push_back(res);
    clear_expression();
  endfunction

  // ---------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------
  function automatic void add_char(logic [7:0] c, logic is_end);
    char_word_t w;
    w.code   = c;
    w.is_end = is_end;
    char_q.push_back(w);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i], i == s.len() - 1);
    exprs_built++;
  endfunction

  function automatic void maybe_space();
    if ($urandom_range(99) < 12) add_char(CH_SPACE, 1'b0);
  endfunction

  // binary operator, now and then some stray code acting as minus
  function automatic void add_oper();
    logic [7:0] c;
    if ($urandom_range(99) < 6) begin
      do c = 8'($urandom_range(255));
      while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE ||
             c == CH_LPAREN || c == CH_RPAREN);
      add_char(c, 1'b0);
    end else begin
      add_char($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
    end
  endfunction

  function automatic void gen_term(int depth);
    int pick, ndig;
    pick = $urandom_range(9);
    maybe_space();
    if (depth < 4 && pick < 2) begin
      add_char(CH_LPAREN, 1'b0);
      gen_expr(depth + 1);
      maybe_space();
      add_char(CH_RPAREN, 1'b0);
    end else if (pick < 3) begin
      // unary sign
      add_oper();
      gen_term(depth);
    end else begin
      // mostly short numbers, sometimes long enough to wrap
      ndig = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
      repeat (ndig) begin
        add_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
        if ($urandom_range(99) < 3) add_char(CH_SPACE, 1'b0);
      end
    end
  endfunction

  function automatic void gen_expr(int depth);
    int nops;
    nops = $urandom_range(3);
    gen_term(depth);
    repeat (nops) begin
      maybe_space();
      add_oper();
      gen_term(depth);
    end
  endfunction

  // close one expression: end mark on the last char or on a trailing space
  function automatic void close_expression();
    if ($urandom_range(4) == 0 || char_q.size() == 0)
      add_char(CH_SPACE, 1'b1);
    else
      char_q[char_q.size() - 1].is_end = 1'b1;
    exprs_built++;
  endfunction

  // junk: any byte, or a jumble of expression characters
  function automatic void gen_noise();
    int         n;
    logic [7:0] c;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1))
        c = 8'($urandom_range(255));
      else
        case ($urandom_range(5))
          0: c = CH_LPAREN;
          1: c = CH_RPAREN;
          2: c = CH_PLUS;
          3: c = CH_MINUS;
          4: c = CH_SPACE;
          default: c = CH_ZERO + 8'($urandom_range(9));
        endcase
      add_char(c, 1'b0);
    end
    close_expression();
  endfunction

  // nesting past the stack depth: the operator stack overflows, the operand stack at 70 levels
  function automatic void gen_deep(int levels, bit closed);
    for (int i = 0; i < levels; i++) begin
      add_char(CH_ZERO + 8'($urandom_range(1, 9)), 1'b0);
      add_char($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
      add_char(CH_LPAREN, 1'b0);
    end
    add_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    if (closed)
      repeat (levels) add_char(CH_RPAREN, 1'b0);
    close_expression();
  endfunction

  // ---------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (err_cnt < MAX_PRINTS)
      $display("mismatch at result %0d: %s expected %0h got %0h",
               results_seen, what, want, got);
    err_cnt++;
  endtask

  // quiet stretch with no idling on either side
  wire steady = chars_sent >= 300 && chars_sent < 500;

  // ---------------------------------------------------------------------
  // character driver, feeds the model on every accepted word
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : char_driver
    char_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        evaluate_char(s_axis_tdata, s_axis_tlast);
        chars_sent <= chars_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
          w = char_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.code;
          s_axis_tlast  <= w.is_end;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // long receiver hold-off, once, after a few results
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == 12) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result ready, random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= 25);
  end

  // ---------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    eval_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (value_q.size() == 0) begin
        report_mismatch("unexpected word, value", '0, m_axis_tdata);
      end else begin
        want = value_q.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("value", want.value, m_axis_tdata);
        if (m_axis_tuser[0] !== want.ovf)
          report_mismatch("overflowed", 32'(want.ovf), 32'(m_axis_tuser));
        if (want.ovf) ovf_seen <= 1'b1;
      end
      results_seen <= results_seen + 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, value_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int base;
    ovf_sticky = 1'b0;
    clear_expression();

    // directed: plain digit, space inside a number, unary after paren and
    // after minus, stray code as operator, unmatched parens, lone space
    add_text("7");
    add_text(" 1 2-3");
    add_text("(-9)");
    add_text("1--2");
    add_text("+a");
    add_text(")");
    add_text("((");
    add_text(" ");

    // random: mostly well-formed, some noise
    base = char_q.size();
    while (char_q.size() - base < RANDOM_CHARS) begin
      if ($urandom_range(99) < 15) begin
        gen_noise();
      end else begin
        gen_expr(0);
        close_expression();
      end
    end

    // deep nesting last, since the overflow flag never clears
    gen_deep(70, 1'b1);
    gen_expr(0);
    close_expression();
    gen_deep(40, 1'b0);
    gen_expr(0);
    close_expression();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || s_axis_tvalid || value_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d characters in %0d expressions, checked %0d results",
             chars_sent, exprs_built, results_seen);
    $display("stack overflow reached: %0d, receiver held off %0d cycles once",
             ovf_seen, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
